// ===== rtl/core/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int unsigned MAX_RES = 6;

    localparam logic [15:0] MAX_BYTES_RST = 16'd4096;
    localparam logic [16:0] LEN_MAX       = 17'h1FFFF;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [20:0] CP_REPL  = 21'h00FFFD;
    localparam logic [20:0] CP_SUPP  = 21'h010000;
    localparam logic [5:0]  SURR_HI  = 6'b110110;
    localparam logic [5:0]  SURR_LO  = 6'b110111;

    typedef enum logic [1:0] {
        ST_DATA      = 2'd0,
        ST_CLOSED    = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } t_utf8;

    // results of one input byte: data bytes then an optional status result
    typedef struct packed {
        logic [2:0]              n_data;
        logic [MAX_RES-1:0][7:0] data;
        logic                    has_tail;
        t_status                 tail;
    } t_bundle;

    function automatic t_hex hex_digit(input logic [7:0] b);
        t_hex r;
        r.ok  = 1'b1;
        r.val = b[3:0];
        if (b inside {[8'h30:8'h39]}) begin
            r.val = b[3:0];
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r.val = b[3:0] + 4'd9;
        end else begin
            r.ok  = 1'b0;
        end
        return r;
    endfunction

    function automatic t_utf8 cp_encode(input logic [20:0] cp);
        t_utf8 r;
        r.b   = '0;
        r.len = 3'd1;
        if (cp < 21'h80) begin
            r.len  = 3'd1;
            r.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.len  = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end else if (cp < CP_SUPP) begin
            r.len  = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end else begin
            r.len  = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/jsu_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_in_if
// Raw string body byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       input_ends;

    modport source (output valid, output in_byte, output input_ends, input ready);
    modport sink   (input valid, input in_byte, input input_ends, output ready);
endinterface

// ===== rtl/core/jsu_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_if
// Decoded UTF-8 byte and status channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== rtl/core/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a JSON string body byte stream into UTF-8 bytes with close and
// error status.
//
// channel  dir  payload                       handshake
// i_in     in   in_byte[8], input_ends[1]     valid / ready
// o_out    out  out_byte[8], status[2], last  valid / ready
// cfg      in   i_cfg_wr_data[16]             i_cfg_wr_en
//
// one byte per cycle when each byte yields at most one result and o_out
// is ready; a byte with more results (up to 6) holds the result register
// until all are taken; results pass the input, then the result register
// reset: synchronous, active low; max length returns to 4096
// stalls on o_out back up through the result and input registers
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    jsu_in_if.sink      i_in,
    jsu_out_if.source   o_out
);

    logic             bundle_valid;
    logic             bundle_ready;
    jsu_pkg::t_bundle bundle;

    jsu_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in           (i_in),
        .o_bundle_valid (bundle_valid),
        .o_bundle       (bundle),
        .i_bundle_ready (bundle_ready)
    );

    jsu_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bundle_valid (bundle_valid),
        .i_bundle       (bundle),
        .o_bundle_ready (bundle_ready),
        .o_out          (o_out)
    );

endmodule

// ===== rtl/core/jsu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Input register, escape/surrogate state and the single-pass decode of one
// byte into a bundle of results.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [15:0]      i_cfg_wr_data,
    jsu_in_if.sink           i_in,
    output logic             o_bundle_valid,
    output jsu_pkg::t_bundle o_bundle,
    input  logic             i_bundle_ready
);

    typedef enum logic [5:0] {
        S_PLAIN   = 6'b000001,
        S_ESC     = 6'b000010,
        S_UHEX    = 6'b000100,
        S_HI_WAIT = 6'b001000,
        S_HI_BSL  = 6'b010000,
        S_HI_U    = 6'b100000
    } t_mode;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_ends;
    logic [15:0] r_max;
    t_mode       r_mode, n_mode;
    logic [15:0] r_acc, n_acc;
    logic [9:0]  r_high, n_high;
    logic [1:0]  r_hcnt, n_hcnt;
    logic [16:0] r_len;

    jsu_pkg::t_hex  hex;
    jsu_pkg::t_utf8 enc;
    jsu_pkg::t_utf8 rep;
    logic [15:0] acc_next;
    logic        hex_done;
    logic        do_plain, do_esc, do_unit;
    logic        pre_fffd, main_en, main_raw;
    logic [7:0]  main_byte;
    logic [20:0] main_cp;
    logic [2:0]  main_len;
    logic [3:0][7:0] main_b;
    logic [2:0]  n_data;
    logic        step_err, step_close, clear;
    logic [17:0] len_sum;
    logic [16:0] len_sat;
    logic        nonempty, advance;

    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_high    = r_high;
        n_hcnt    = r_hcnt;
        do_plain  = 1'b0;
        do_esc    = 1'b0;
        do_unit   = 1'b0;
        pre_fffd  = 1'b0;
        main_en   = 1'b0;
        main_raw  = 1'b0;
        main_byte = r_in_byte;
        main_cp   = '0;
        step_err  = 1'b0;
        step_close = 1'b0;
        hex       = jsu_pkg::hex_digit(r_in_byte);
        acc_next  = {r_acc[11:0], hex.val};
        hex_done  = hex.ok && (r_hcnt == 2'd3);

        case (r_mode)
            S_ESC: begin
                do_esc = 1'b1;
            end
            S_UHEX: begin
                if (!hex.ok) begin
                    step_err = 1'b1;
                end else begin
                    n_acc  = acc_next;
                    n_hcnt = r_hcnt + 2'd1;
                    do_unit = hex_done;
                end
            end
            S_HI_WAIT: begin
                if (r_in_byte == jsu_pkg::CH_BSL) begin
                    n_mode = S_HI_BSL;
                end else begin
                    pre_fffd = 1'b1;
                    do_plain = 1'b1;
                end
            end
            S_HI_BSL: begin
                if (r_in_byte == jsu_pkg::CH_U) begin
                    n_mode = S_HI_U;
                    n_acc  = '0;
                    n_hcnt = '0;
                end else begin
                    pre_fffd = 1'b1;
                    do_esc   = 1'b1;
                end
            end
            S_HI_U: begin
                if (!hex.ok) begin
                    step_err = 1'b1;
                end else begin
                    n_acc  = acc_next;
                    n_hcnt = r_hcnt + 2'd1;
                    if (hex_done) begin
                        if (acc_next[15:10] == jsu_pkg::SURR_LO) begin
                            main_en = 1'b1;
                            main_cp = jsu_pkg::CP_SUPP + {1'b0, r_high, acc_next[9:0]};
                            n_mode  = S_PLAIN;
                        end else begin
                            pre_fffd = 1'b1;
                            do_unit  = 1'b1;
                        end
                    end
                end
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase

        if (do_plain) begin
            n_mode = S_PLAIN;
            if (r_in_byte == jsu_pkg::CH_QUOTE) begin
                step_close = 1'b1;
            end else if (r_in_byte == jsu_pkg::CH_BSL) begin
                n_mode = S_ESC;
            end else if (r_in_byte < jsu_pkg::CH_SPACE) begin
                step_err = 1'b1;
            end else begin
                main_en  = 1'b1;
                main_raw = 1'b1;
            end
        end

        if (do_esc) begin
            n_mode   = S_PLAIN;
            main_en  = 1'b1;
            main_raw = 1'b1;
            case (r_in_byte)
                jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: main_byte = r_in_byte;
                jsu_pkg::CH_B: main_byte = 8'h08;
                jsu_pkg::CH_F: main_byte = 8'h0C;
                jsu_pkg::CH_N: main_byte = 8'h0A;
                jsu_pkg::CH_R: main_byte = 8'h0D;
                jsu_pkg::CH_T: main_byte = 8'h09;
                jsu_pkg::CH_U: begin
                    main_en  = 1'b0;
                    main_raw = 1'b0;
                    n_mode   = S_UHEX;
                    n_acc    = '0;
                    n_hcnt   = '0;
                end
                default: begin
                    main_en  = 1'b0;
                    main_raw = 1'b0;
                    step_err = 1'b1;
                end
            endcase
        end

        if (do_unit) begin
            if (acc_next[15:10] == jsu_pkg::SURR_HI) begin
                n_high = acc_next[9:0];
                n_mode = S_HI_WAIT;
            end else begin
                main_en = 1'b1;
                main_cp = (acc_next[15:10] == jsu_pkg::SURR_LO) ? jsu_pkg::CP_REPL
                                                                : {5'b0, acc_next};
                n_mode  = S_PLAIN;
            end
        end

        if (r_in_ends && !step_close) begin
            step_err = 1'b1;
        end
    end

    // assemble the data bytes: optional replacement char, then the main unit
    always_comb begin
        enc = jsu_pkg::cp_encode(main_cp);
        rep = jsu_pkg::cp_encode(jsu_pkg::CP_REPL);
        main_b = enc.b;
        main_len = enc.len;
        if (main_raw) begin
            main_b    = '0;
            main_b[0] = main_byte;
            main_len  = 3'd1;
        end
        if (!main_en) begin
            main_len = 3'd0;
        end
        n_data = (pre_fffd ? 3'd3 : 3'd0) + main_len;

        o_bundle.data = '0;
        if (pre_fffd) begin
            o_bundle.data[2:0] = rep.b[2:0];
            o_bundle.data[5:3] = main_b[2:0];
        end else begin
            o_bundle.data[3:0] = main_b;
        end

        len_sum  = {1'b0, r_len} + {15'b0, n_data};
        len_sat  = (len_sum > {1'b0, jsu_pkg::LEN_MAX}) ? jsu_pkg::LEN_MAX : len_sum[16:0];
        clear    = step_err || step_close;
        nonempty = clear || (n_data != 3'd0);

        o_bundle.n_data   = step_err ? 3'd0 : n_data;
        o_bundle.has_tail = clear;
        if (step_err) begin
            o_bundle.tail = jsu_pkg::ST_MALFORMED;
        end else if (len_sat > {1'b0, r_max}) begin
            o_bundle.tail = jsu_pkg::ST_TOO_LONG;
        end else begin
            o_bundle.tail = jsu_pkg::ST_CLOSED;
        end
    end

    assign advance        = r_in_valid && (i_bundle_ready || !nonempty);
    assign o_bundle_valid = r_in_valid && nonempty;
    assign i_in.ready     = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max      <= jsu_pkg::MAX_BYTES_RST;
            r_mode     <= S_PLAIN;
            r_acc      <= '0;
            r_high     <= '0;
            r_hcnt     <= '0;
            r_len      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                if (clear) begin
                    r_mode <= S_PLAIN;
                    r_acc  <= '0;
                    r_high <= '0;
                    r_hcnt <= '0;
                    r_len  <= '0;
                end else begin
                    r_mode <= n_mode;
                    r_acc  <= n_acc;
                    r_high <= n_high;
                    r_hcnt <= n_hcnt;
                    r_len  <= len_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_ends <= i_in.input_ends;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && clear) |=> (r_len == '0 && r_mode == S_PLAIN && r_hcnt == '0))
        else $error("state not cleared after close or error");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !clear) |=> (r_len >= $past(r_len)))
        else $error("decoded length went backwards");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bundle_valid && o_bundle.tail == jsu_pkg::ST_MALFORMED && o_bundle.has_tail)
        |-> (o_bundle.n_data == 3'd0))
        else $error("data bytes kept with a malformed result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost");

endmodule

// ===== rtl/core/jsu_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_emit
// Result register holding one bundle; hands its results out one per
// transaction and flags the final one.
// ----------------------------------------------------------------------------
module jsu_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_bundle_valid,
    input  jsu_pkg::t_bundle i_bundle,
    output logic             o_bundle_ready,
    jsu_out_if.source        o_out
);

    logic             r_valid;
    jsu_pkg::t_bundle r_bundle;
    logic [2:0]       r_idx;

    logic [2:0] total;
    logic       is_last;
    logic       load;
    logic       take;

    assign total   = r_bundle.n_data + {2'b0, r_bundle.has_tail};
    assign is_last = (r_idx == total - 3'd1);
    assign take    = r_valid && o_out.ready;
    assign o_bundle_ready = !r_valid || (o_out.ready && is_last);
    assign load    = i_bundle_valid && o_bundle_ready;

    assign o_out.valid = r_valid;
    assign o_out.last  = is_last;
    always_comb begin
        if (r_idx < r_bundle.n_data) begin
            o_out.out_byte = r_bundle.data[r_idx];
            o_out.status   = jsu_pkg::ST_DATA;
        end else begin
            o_out.out_byte = 8'h00;
            o_out.status   = r_bundle.tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bundle <= i_bundle;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx < total))
        else $error("result index past end of bundle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != jsu_pkg::ST_DATA) |-> o_out.last)
        else $error("status result not last");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_valid && r_idx == '0 && total != 3'd0))
        else $error("empty bundle loaded");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the JSON string unescaper. A table of directed bytes
// (extremes, escapes, a surrogate pair, a lone surrogate, each error) is sent
// first, then random strings built mostly from well-formed tokens under several
// maximum-length settings. Each accepted byte is run through a decoder model
// kept in the bench, and every output transaction is compared field by field
// with the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASE_BYTES   = 16;

    typedef enum logic [2:0] {
        M_PLAIN, M_ESC, M_UHEX, M_HI_WAIT, M_HI_BSL, M_HI_U
    } t_mode;

    typedef struct packed {
        logic [7:0]       ob;
        jsu_pkg::t_status st;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [7:0]       ch;
        logic             ends;
        logic             typed;
        jsu_pkg::t_status st;
        logic [7:0]       ob;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_utf8 u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // decoder model state
    t_mode       dec_mode;
    logic [15:0] dec_accum;
    logic [9:0]  dec_high;
    logic [1:0]  dec_hex_cnt;
    logic [16:0] dec_len;
    logic [15:0] max_len;
    logic [7:0]  step_out[$];
    bit          step_err;
    bit          step_close;

    t_result     decoded_due[$];
    logic [7:0]  text_q[$];
    bit          text_fin;
    bit          gaps_on;
    bit          hold_req;
    int          fails;
    int          bytes_in;
    int          seen_st[4];

    logic [7:0] esc_chars [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH,
                                  jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                                  jsu_pkg::CH_R, jsu_pkg::CH_T};

    t_row directed_rows [32] = '{
        '{jsu_pkg::CH_SPACE, 1'b0, 1'b1, jsu_pkg::ST_DATA,      8'h20},
        '{8'hFF,             1'b0, 1'b1, jsu_pkg::ST_DATA,      8'hFF},
        '{jsu_pkg::CH_QUOTE, 1'b0, 1'b1, jsu_pkg::ST_CLOSED,    8'h00},
        '{8'h1F,             1'b0, 1'b1, jsu_pkg::ST_MALFORMED, 8'h00},
        '{8'h00,             1'b0, 1'b1, jsu_pkg::ST_MALFORMED, 8'h00},
        '{jsu_pkg::CH_BSL,   1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h71,             1'b0, 1'b1, jsu_pkg::ST_MALFORMED, 8'h00},
        '{jsu_pkg::CH_BSL,   1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{jsu_pkg::CH_T,     1'b0, 1'b1, jsu_pkg::ST_DATA,      8'h09},
        '{jsu_pkg::CH_BSL,   1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{jsu_pkg::CH_U,     1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h44,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h38,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h33,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h64,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{jsu_pkg::CH_BSL,   1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{jsu_pkg::CH_U,     1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h44,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h45,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h30,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h30,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{jsu_pkg::CH_BSL,   1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{jsu_pkg::CH_U,     1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h64,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h63,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h30,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h30,             1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{jsu_pkg::CH_BSL,   1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{jsu_pkg::CH_U,     1'b0, 1'b0, jsu_pkg::ST_DATA,      8'h00},
        '{8'h67,             1'b0, 1'b1, jsu_pkg::ST_MALFORMED, 8'h00},
        '{8'h78,             1'b1, 1'b1, jsu_pkg::ST_MALFORMED, 8'h00},
        '{jsu_pkg::CH_QUOTE, 1'b1, 1'b1, jsu_pkg::ST_CLOSED,    8'h00}
    };

    task automatic clear_decoder();
        dec_mode    = M_PLAIN;
        dec_accum   = '0;
        dec_high    = '0;
        dec_hex_cnt = '0;
        dec_len     = '0;
    endtask

    task automatic put_out(input logic [7:0] b);
        step_out.push_back(b);
        if (dec_len != jsu_pkg::LEN_MAX) dec_len++;
    endtask

    task automatic put_cp(input logic [20:0] cp);
        if (cp < 21'h80) begin
            put_out(cp[7:0]);
        end else if (cp < 21'h800) begin
            put_out(8'hC0 | cp[10:6]);
            put_out(8'h80 | cp[5:0]);
        end else if (cp < 21'h10000) begin
            put_out(8'hE0 | cp[15:12]);
            put_out(8'h80 | cp[11:6]);
            put_out(8'h80 | cp[5:0]);
        end else begin
            put_out(8'hF0 | cp[20:18]);
            put_out(8'h80 | cp[17:12]);
            put_out(8'h80 | cp[11:6]);
            put_out(8'h80 | cp[5:0]);
        end
    endtask

    // full \u value outside a pair
    task automatic take_unit(input logic [15:0] cp);
        if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
            dec_high = cp[9:0];
            dec_mode = M_HI_WAIT;
        end else begin
            if (cp >= 16'hDC00 && cp <= 16'hDFFF) put_cp(jsu_pkg::CP_REPL);
            else put_cp({5'd0, cp});
            dec_mode = M_PLAIN;
        end
    endtask

    task automatic plain_char(input logic [7:0] ch);
        if (ch == jsu_pkg::CH_QUOTE) step_close = 1'b1;
        else if (ch == jsu_pkg::CH_BSL) dec_mode = M_ESC;
        else if (ch < jsu_pkg::CH_SPACE) step_err = 1'b1;
        else put_out(ch);
    endtask

    task automatic escape_char(input logic [7:0] ch);
        dec_mode = M_PLAIN;
        case (ch)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: put_out(ch);
            jsu_pkg::CH_B: put_out(8'h08);
            jsu_pkg::CH_F: put_out(8'h0C);
            jsu_pkg::CH_N: put_out(8'h0A);
            jsu_pkg::CH_R: put_out(8'h0D);
            jsu_pkg::CH_T: put_out(8'h09);
            jsu_pkg::CH_U: begin
                dec_mode    = M_UHEX;
                dec_accum   = '0;
                dec_hex_cnt = '0;
            end
            default: step_err = 1'b1;
        endcase
    endtask

    function automatic logic [4:0] nibble_of(input logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39) return {1'b1, ch[3:0]};
        if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
            return {1'b1, ch[3:0] + 4'd9};
        return 5'd0;
    endfunction

    task automatic take_hex(input logic [7:0] ch, output bit done);
        logic [4:0] nib;
        nib  = nibble_of(ch);
        done = 1'b0;
        if (!nib[4]) begin
            step_err = 1'b1;
        end else begin
            dec_accum = {dec_accum[11:0], nib[3:0]};
            if (dec_hex_cnt == 2'd3) begin
                dec_hex_cnt = '0;
                done        = 1'b1;
            end else begin
                dec_hex_cnt++;
            end
        end
    endtask

    // predicts the results of one input byte and queues them
    task automatic unescape_byte(input logic [7:0] ch, input logic fin, output int made);
        bit done;
        step_out.delete();
        step_err   = 1'b0;
        step_close = 1'b0;
        made       = 0;
        case (dec_mode)
            M_ESC: escape_char(ch);
            M_UHEX: begin
                take_hex(ch, done);
                if (done) take_unit(dec_accum);
            end
            M_HI_WAIT: begin
                if (ch == jsu_pkg::CH_BSL) begin
                    dec_mode = M_HI_BSL;
                end else begin
                    put_cp(jsu_pkg::CP_REPL);
                    dec_mode = M_PLAIN;
                    plain_char(ch);
                end
            end
            M_HI_BSL: begin
                if (ch == jsu_pkg::CH_U) begin
                    dec_mode    = M_HI_U;
                    dec_accum   = '0;
                    dec_hex_cnt = '0;
                end else begin
                    put_cp(jsu_pkg::CP_REPL);
                    escape_char(ch);
                end
            end
            M_HI_U: begin
                take_hex(ch, done);
                if (done) begin
                    if (dec_accum >= 16'hDC00 && dec_accum <= 16'hDFFF) begin
                        put_cp(21'h10000 + {dec_high, 10'd0} + (dec_accum - 16'hDC00));
                        dec_mode = M_PLAIN;
                    end else begin
                        put_cp(jsu_pkg::CP_REPL);
                        take_unit(dec_accum);
                    end
                end
            end
            default: begin
                dec_mode = M_PLAIN;
                plain_char(ch);
            end
        endcase
        if (fin && !step_close) step_err = 1'b1;
        if (step_err) begin
            clear_decoder();
            decoded_due.push_back('{8'h00, jsu_pkg::ST_MALFORMED, 1'b1});
            made = 1;
        end else begin
            foreach (step_out[i]) begin
                decoded_due.push_back('{step_out[i], jsu_pkg::ST_DATA,
                                        (i == step_out.size() - 1) && !step_close});
                made++;
            end
            if (step_close) begin
                decoded_due.push_back('{8'h00,
                    ({1'b0, max_len} < dec_len) ? jsu_pkg::ST_TOO_LONG
                                                : jsu_pkg::ST_CLOSED, 1'b1});
                made++;
                clear_decoder();
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] ch, input logic fin, output int made);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= ch;
        in_ch.input_ends <= fin;
        do @(posedge clk); while (!in_ch.ready);
        unescape_byte(ch, fin, made);
        bytes_in++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max(input logic [15:0] lim);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        max_len = lim;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    function automatic logic [7:0] plain_pick();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL);
        return b;
    endfunction

    task automatic push_u(input logic [15:0] v);
        text_q.push_back(jsu_pkg::CH_BSL);
        text_q.push_back(jsu_pkg::CH_U);
        for (int k = 3; k >= 0; k--) text_q.push_back(hex_char(v[k*4 +: 4]));
    endtask

    function automatic logic [15:0] high_pick();
        return 16'($urandom_range(16'hD800, 16'hDBFF));
    endfunction

    function automatic logic [15:0] low_pick();
        return 16'($urandom_range(16'hDC00, 16'hDFFF));
    endfunction

    // one random string body, mostly well-formed tokens
    task automatic build_string();
        int          pick;
        logic [7:0]  b;
        logic [15:0] v;
        text_q.delete();
        repeat ($urandom_range(0, 6)) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                text_q.push_back(plain_pick());
            end else if (pick < 55) begin
                text_q.push_back(jsu_pkg::CH_BSL);
                text_q.push_back(esc_chars[$urandom_range(0, 7)]);
            end else if (pick < 70) begin
                case ($urandom_range(0, 4))
                    0: v = 16'($urandom_range(0, 16'h7F));
                    1: v = 16'($urandom_range(16'h80, 16'h7FF));
                    2: v = 16'($urandom_range(16'h800, 16'hFFFF));
                    3: v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
                push_u(v);
            end else if (pick < 80) begin
                push_u(high_pick());
                push_u(low_pick());
            end else if (pick < 85) begin
                push_u(high_pick());
            end else if (pick < 89) begin
                push_u(low_pick());
            end else if (pick < 93) begin
                push_u(high_pick());
                v = ($urandom_range(0, 1) != 0) ? high_pick()
                                                : 16'($urandom_range(0, 16'hD7FF));
                push_u(v);
            end else if (pick < 96) begin
                // high half then a backslash that turns out to be another escape
                push_u(high_pick());
                text_q.push_back(jsu_pkg::CH_BSL);
                text_q.push_back(esc_chars[$urandom_range(0, 7)]);
            end else begin
                case ($urandom_range(0, 2))
                    0: text_q.push_back(8'($urandom_range(0, 8'h1F)));
                    1: begin
                        do b = 8'($urandom_range(0, 255));
                        while (b inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL,
                                         jsu_pkg::CH_SLASH, jsu_pkg::CH_B, jsu_pkg::CH_F,
                                         jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T,
                                         jsu_pkg::CH_U});
                        text_q.push_back(jsu_pkg::CH_BSL);
                        text_q.push_back(b);
                    end
                    default: begin
                        text_q.push_back(jsu_pkg::CH_BSL);
                        text_q.push_back(jsu_pkg::CH_U);
                        repeat ($urandom_range(0, 3))
                            text_q.push_back(hex_char(4'($urandom_range(0, 15))));
                        do b = 8'($urandom_range(0, 255)); while (nibble_of(b) != 5'd0);
                        text_q.push_back(b);
                    end
                endcase
            end
        end
        if ($urandom_range(0, 9) < 8) begin
            text_q.push_back(jsu_pkg::CH_QUOTE);
            text_fin = ($urandom_range(0, 3) == 0);
        end else begin
            if (text_q.size() == 0) text_q.push_back(plain_pick());
            text_fin = 1'b1;
        end
    endtask

    task automatic run_phase(input logic [15:0] lim, input bit squeeze, input bit gaps);
        int sent;
        int made;
        write_max(lim);
        gaps_on  = gaps;
        hold_req = squeeze;
        sent     = 0;
        while (sent < PHASE_BYTES) begin
            build_string();
            foreach (text_q[k])
                send_byte(text_q[k], (k == text_q.size() - 1) ? text_fin : 1'b0, made);
            sent += text_q.size();
        end
    endtask

    // receiver: random hold-offs, one long hold on request
    initial begin : sink_ready
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : out_check
        t_result want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (decoded_due.size() == 0) begin
                $display("%0t: unexpected transaction byte %h status %0d last %0b",
                         $time, out_ch.out_byte, out_ch.status, out_ch.last);
                fails++;
            end else begin
                want = decoded_due.pop_front();
                seen_st[want.st]++;
                if (out_ch.out_byte !== want.ob) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.ob, out_ch.out_byte);
                    fails++;
                end
                if (out_ch.status !== want.st) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, out_ch.status);
                    fails++;
                end
                if (out_ch.last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, out_ch.last);
                    fails++;
                end
            end
        end
    end

    initial begin : stimulus
        int made;
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.in_byte    <= '0;
        in_ch.input_ends <= 1'b0;
        fails    = 0;
        bytes_in = 0;
        gaps_on  = 1'b1;
        hold_req = 1'b0;
        max_len  = jsu_pkg::MAX_BYTES_RST;
        clear_decoder();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].ch, directed_rows[i].ends, made);
            if (directed_rows[i].typed) begin
                repeat (made) void'(decoded_due.pop_back());
                decoded_due.push_back('{directed_rows[i].ob, directed_rows[i].st, 1'b1});
            end
        end

        run_phase(16'd0,     1'b0, 1'b1);
        run_phase(16'hFFFF,  1'b1, 1'b1);
        run_phase(16'd6,     1'b0, 1'b1);
        run_phase(16'd1,     1'b0, 1'b1);
        run_phase(16'd23,    1'b0, 1'b1);
        run_phase(16'd4096,  1'b0, 1'b0);
        wait_idle();

        $display("covered %0d input bytes over six length limits from 0 to 65535", bytes_in);
        $display("results checked: %0d data, %0d closed, %0d too long, %0d malformed",
                 seen_st[jsu_pkg::ST_DATA], seen_st[jsu_pkg::ST_CLOSED],
                 seen_st[jsu_pkg::ST_TOO_LONG], seen_st[jsu_pkg::ST_MALFORMED]);
        if (fails == 0) begin
            $display("[json_string_unescape_utf8] OK");
        end else begin
            $display("[json_string_unescape_utf8] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("timeout with %0d results still due", decoded_due.size());
        $display("[json_string_unescape_utf8] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/jsu_pkg.sv
rtl/core/jsu_in_if.sv
rtl/core/jsu_out_if.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_emit.sv
rtl/core/json_string_unescape_utf8.sv
tb/testbench.sv
